// ===== rtl/hfi_pkg.sv =====
// Shared constants, types and helper functions for the HF injection identifier.
// Used by every module under rtl/; depends on nothing else.
package hfi_pkg;

  // Default number of CORDIC micro-rotations
  localparam int CORDIC_ITERATIONS_DEF = 24;

  // Configuration register indexes
  localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [2:0] CFG_PHASE_OFFSET = 3'd1;
  localparam logic [2:0] CFG_DEMOD_GAIN   = 3'd2;
  localparam logic [2:0] CFG_INJECT_AMPL  = 3'd3;
  localparam logic [2:0] CFG_INV_OMEGA    = 3'd4;

  // Filter coefficients, Q2.30, and other constants, as operands of the shared multiplier
  localparam logic signed [35:0] BP_A1    = 36'sd2098091524;
  localparam logic signed [35:0] BP_A2    = 36'sd1040563202;
  localparam logic signed [35:0] BP_B     = 36'sd33124935;
  localparam logic signed [35:0] LP_A1    = 36'sd2100239008;
  localparam logic signed [35:0] LP_A2    = 36'sd1027034055;
  localparam logic signed [35:0] LP_B1    = 36'sd522053;
  localparam logic signed [35:0] LP_B0    = 36'sd514430;
  localparam logic signed [35:0] CORDIC_K = 36'sd652032874;
  localparam logic signed [35:0] Z_CONST  = 36'sd4451026116;

  // Impedance limit, ten ohms in Q8.24
  localparam logic [63:0]        Z_LIMIT_U = 64'd167772160;
  localparam logic signed [71:0] Z_LIMIT_S = 72'sd167772160;

  localparam logic signed [71:0] I32_MAX = 72'sd2147483647;
  localparam logic signed [71:0] I32_MIN = -72'sd2147483648;

  localparam int DIV_W = 64;

  typedef struct packed {
    logic start;
    logic vector_mode;
  } cordic_cmd_t;

  // atan(2^-i) in turns / 2^32
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      5'd28: r = 30'd3;
      5'd29: r = 30'd1;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Arithmetic right shift, rounding half up
  function automatic logic signed [71:0] rnd_shr(input logic signed [71:0] v,
                                                 input logic [5:0] s);
    logic signed [71:0] half;
    half = 72'sd1 <<< (s - 6'd1);
    return (v + half) >>> s;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
    logic signed [31:0] r;
    if (v > I32_MAX) r = 32'sh7fffffff;
    else if (v < I32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/hfi_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on hfi_pkg (arctangent table, CORDIC gain, command struct).
module hfi_cordic #(
  parameter int CORDIC_ITERATIONS = hfi_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hfi_pkg::cordic_cmd_t     cmd_i,
  input  logic [31:0]              turn_i,
  input  logic signed [35:0]       x_i,
  input  logic signed [35:0]       y_i,
  output logic                     done_o,
  output logic signed [35:0]       x_o,
  output logic signed [35:0]       y_o,
  output logic signed [33:0]       z_o
);
  import hfi_pkg::*;

  localparam int NIT = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
  localparam logic [4:0] LAST = 5'(NIT - 1);

  logic              busy_q, busy_d, done_q, done_d, vec_q, vec_d, flip_q, flip_d;
  logic [4:0]        cnt_q, cnt_d;
  logic signed [35:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [33:0] z_q, z_d, at;
  logic              flip;
  logic [31:0]       fold;

  always_comb begin
    flip   = turn_i[31] ^ turn_i[30];
    fold   = flip ? (turn_i + 32'h8000_0000) : turn_i;
    dx     = y_q >>> cnt_q;
    dy     = x_q >>> cnt_q;
    at     = $signed({4'b0, atan_turn(cnt_q)});
    busy_d = busy_q;
    done_d = 1'b0;
    vec_d  = vec_q;
    flip_d = flip_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (cmd_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      vec_d  = cmd_i.vector_mode;
      if (cmd_i.vector_mode) begin
        flip_d = 1'b0;
        x_d    = x_i;
        y_d    = y_i;
        z_d    = '0;
      end else begin
        flip_d = flip;
        x_d    = CORDIC_K;
        y_d    = '0;
        z_d    = 34'($signed(fold));
      end
    end else if (busy_q) begin
      if (vec_q) begin
        if (y_q > 36'sd0) begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
        end else if (y_q < 36'sd0) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
        end
      end else begin
        if (!z_q[33]) begin
          x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - at;
        end else begin
          x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + at;
        end
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    flip_q <= flip_d;
    cnt_q  <= cnt_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign done_o = done_q;
  assign x_o    = flip_q ? -x_q : x_q;
  assign y_o    = flip_q ? -y_q : y_q;
  assign z_o    = z_q;

endmodule

// ===== rtl/hfi_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hfi_pkg for the operand width.
module hfi_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hfi_pkg::DIV_W-1:0]  dividend_i,
  input  logic [hfi_pkg::DIV_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [hfi_pkg::DIV_W-1:0]  quotient_o
);
  import hfi_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic              busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DIV_W-1:0]  dq_q, dq_d, rem_q, rem_d, dsr_q, dsr_d;
  logic [DIV_W:0]    rem_sh;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    rem_sh = {rem_q, dq_q[DIV_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dq_d   = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d = DIV_W'(rem_sh - {1'b0, dsr_q});
        dq_d  = {dq_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIV_W-1:0];
        dq_d  = {dq_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

// ===== rtl/hfi_isqrt.sv =====
// Floor integer square root of a 64-bit value, one result bit per cycle.
// Depends on hfi_pkg for nothing but the shared import convention.
module hfi_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import hfi_pkg::*;

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [63:0] v_q, v_d, r_q, r_d, bitv, trial;
  logic [5:0]  sh;

  always_comb begin
    sh     = 6'd62 - {cnt_q, 1'b0};
    bitv   = 64'd1 << sh;
    trial  = r_q + bitv;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      v_d    = value_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_d = v_q - trial;
        r_d = (r_q >> 1) + bitv;
      end else begin
        r_d = r_q >> 1;
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    v_q   <= v_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

// ===== rtl/hf_injection_rs_ls_identifier.sv =====
// HF injection resistance / inductance identifier, top level.
// Processing of each sample is dominated by three divisions, two square roots and the CORDIC passes;
// the zeroed path skips the later steps and finishes sooner.
// A new sample is taken only in idle, once the last one's result is registered; a waiting result holds it back.
// Reset (rst_ni low, async): filters, phase, sums and count clear; registers reload defaults.
// Depends on hfi_pkg, hfi_cordic, hfi_div and hfi_isqrt.
module hf_injection_rs_ls_identifier #(
  parameter int CORDIC_ITERATIONS = hfi_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] current_sample_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [28:0] resistance_o,
  output logic signed [31:0] inductance_o,
  output logic               impedance_zeroed_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import hfi_pkg::*;

  // Sequencer states
  localparam logic [5:0] S_IDLE     = 6'd0;
  localparam logic [5:0] S_BP0      = 6'd1;
  localparam logic [5:0] S_BP1      = 6'd2;
  localparam logic [5:0] S_BP2      = 6'd3;
  localparam logic [5:0] S_BP3      = 6'd4;
  localparam logic [5:0] S_BP4      = 6'd5;
  localparam logic [5:0] S_SC_WAIT  = 6'd6;
  localparam logic [5:0] S_DM0      = 6'd7;
  localparam logic [5:0] S_DM1      = 6'd8;
  localparam logic [5:0] S_DM2      = 6'd9;
  localparam logic [5:0] S_DM3      = 6'd10;
  localparam logic [5:0] S_LP0      = 6'd11;
  localparam logic [5:0] S_LP1      = 6'd12;
  localparam logic [5:0] S_LP2      = 6'd13;
  localparam logic [5:0] S_LP3      = 6'd14;
  localparam logic [5:0] S_LP4      = 6'd15;
  localparam logic [5:0] S_LP5      = 6'd16;
  localparam logic [5:0] S_SQ0      = 6'd17;
  localparam logic [5:0] S_SQ1      = 6'd18;
  localparam logic [5:0] S_MEAN     = 6'd19;
  localparam logic [5:0] S_ROOT     = 6'd20;
  localparam logic [5:0] S_VEC      = 6'd21;
  localparam logic [5:0] S_VEC_WAIT = 6'd22;
  localparam logic [5:0] S_MAG0     = 6'd23;
  localparam logic [5:0] S_MAG1     = 6'd24;
  localparam logic [5:0] S_ZNUM     = 6'd25;
  localparam logic [5:0] S_ZDIV     = 6'd26;
  localparam logic [5:0] S_ROT_WAIT = 6'd27;
  localparam logic [5:0] S_RS0      = 6'd28;
  localparam logic [5:0] S_RS1      = 6'd29;
  localparam logic [5:0] S_LS0      = 6'd30;
  localparam logic [5:0] S_LS1      = 6'd31;
  localparam logic [5:0] S_LS2      = 6'd32;
  localparam logic [5:0] S_OUT      = 6'd33;

  // Control and configuration state
  logic [5:0]  state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        k_q, k_d;
  logic [31:0] phase_step_q, phase_offset_q, inv_omega_q;
  logic [15:0] demod_gain_q, inject_ampl_q;

  // Filter and statistics state (reset to zero)
  logic [31:0]        phase_acc_q, phase_acc_d;
  logic signed [31:0] bh0_q, bh0_d, bh1_q, bh1_d;
  logic signed [15:0] bh2_q, bh2_d;
  logic signed [31:0] lh0_q [2];
  logic signed [31:0] lh0_d [2];
  logic signed [31:0] lh1_q [2];
  logic signed [31:0] lh1_d [2];
  logic signed [31:0] lh2_q [2];
  logic signed [31:0] lh2_d [2];
  logic [63:0]        sum_q [2];
  logic [63:0]        sum_d [2];
  logic [31:0]        count_q, count_d;

  // Datapath working registers
  logic signed [15:0] sample_q, sample_d;
  logic signed [71:0] prod_q, acc_q, acc_d;
  logic signed [31:0] hf_q, hf_d, pv_q, pv_d, v_q, v_d;
  logic signed [35:0] s_q, s_d, c_q, c_d, tmp_q, tmp_d;
  logic signed [35:0] vx_q, vx_d, mag_q, mag_d, zq_q, zq_d;
  logic [31:0]        rms_q [2];
  logic [31:0]        rms_d [2];
  logic [31:0]        ang_q, ang_d;
  logic signed [28:0] rs_q, rs_d;
  logic signed [31:0] ls_q, ls_d;
  logic               zero_q, zero_d;
  logic signed [28:0] res_q, res_d;
  logic signed [31:0] ind_q, ind_d;
  logic               izero_q, izero_d;

  // Shared multiplier
  logic signed [35:0] mul_a, mul_b;

  // Helpers
  logic signed [16:0] bp_diff;
  logic signed [71:0] r30, r16, r25;
  logic [64:0]        sum_ext;
  logic [63:0]        sum_new;

  // Unit hookups
  cordic_cmd_t        cor_cmd;
  logic [31:0]        cor_turn;
  logic               cor_done;
  logic signed [35:0] cor_x, cor_y;
  logic signed [33:0] cor_z;
  logic               div_start, div_done;
  logic [DIV_W-1:0]   div_dvd, div_dsr, div_quo;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;

  logic in_fire, cfg_fire, out_free;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  hfi_cordic #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cor_cmd),
    .turn_i (cor_turn),
    .x_i    ($signed({4'b0, rms_q[0]})),
    .y_i    ($signed({4'b0, rms_q[1]})),
    .done_o (cor_done),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  hfi_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  hfi_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (div_quo),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Operand selection for the shared multiplier; product lands in prod_q next cycle
  always_comb begin
    bp_diff = {sample_q[15], sample_q} - {bh2_q[15], bh2_q};
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_BP0:  begin mul_a = BP_A1; mul_b = 36'(bh0_q); end
      S_BP1:  begin mul_a = BP_A2; mul_b = 36'(bh1_q); end
      S_BP2:  begin mul_a = BP_B;  mul_b = 36'($signed({bp_diff, 10'b0})); end
      S_DM0:  begin mul_a = 36'(hf_q); mul_b = k_q ? c_q : s_q; end
      S_DM2:  begin mul_a = tmp_q; mul_b = $signed({20'b0, demod_gain_q}); end
      S_LP0:  begin mul_a = LP_A1; mul_b = 36'(lh0_q[k_q]); end
      S_LP1:  begin mul_a = LP_A2; mul_b = 36'(lh1_q[k_q]); end
      S_LP2:  begin mul_a = LP_B1; mul_b = 36'(lh2_q[k_q]); end
      S_LP3:  begin mul_a = LP_B0; mul_b = 36'(pv_q); end
      S_SQ0:  begin mul_a = 36'(v_q); mul_b = 36'(v_q); end
      S_MAG0: begin mul_a = vx_q; mul_b = CORDIC_K; end
      S_MAG1: begin mul_a = $signed({20'b0, inject_ampl_q}); mul_b = Z_CONST; end
      S_RS0:  begin mul_a = zq_q; mul_b = c_q; end
      S_RS1:  begin mul_a = zq_q; mul_b = s_q; end
      S_LS1:  begin mul_a = tmp_q; mul_b = $signed({4'b0, inv_omega_q}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Sequencer
  always_comb begin
    r30     = rnd_shr(prod_q, 6'd30);
    r16     = rnd_shr(prod_q, 6'd16);
    r25     = rnd_shr(prod_q, 6'd25);
    sum_ext = {1'b0, sum_q[k_q]} + {1'b0, prod_q[63:0]};
    sum_new = sum_ext[64] ? '1 : sum_ext[63:0];

    state_d     = state_q;
    k_d         = k_q;
    phase_acc_d = phase_acc_q;
    bh0_d = bh0_q; bh1_d = bh1_q; bh2_d = bh2_q;
    lh0_d = lh0_q; lh1_d = lh1_q; lh2_d = lh2_q;
    sum_d   = sum_q;
    count_d = count_q;
    sample_d = sample_q;
    acc_d = acc_q; hf_d = hf_q; pv_d = pv_q; v_d = v_q;
    s_d = s_q; c_d = c_q; tmp_d = tmp_q;
    vx_d = vx_q; mag_d = mag_q; zq_d = zq_q;
    rms_d = rms_q; ang_d = ang_q;
    rs_d = rs_q; ls_d = ls_q; zero_d = zero_q;
    res_d = res_q; ind_d = ind_q; izero_d = izero_q;

    // Drop the result word once taken
    out_valid_d = out_valid_q && out_stall_i;

    cor_cmd   = '{start: 1'b0, vector_mode: 1'b0};
    cor_turn  = phase_acc_q + phase_offset_q;
    div_start = 1'b0;
    div_dvd   = sum_new;
    div_dsr   = 64'({1'b0, count_q} + 33'd1);
    sq_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sample_d = current_sample_i;
          k_d      = 1'b0;
          zero_d   = 1'b0;
          rs_d     = '0;
          ls_d     = '0;
          state_d  = S_BP0;
        end
      end
      S_BP0: state_d = S_BP1;
      S_BP1: begin acc_d = prod_q;         state_d = S_BP2; end
      S_BP2: begin acc_d = acc_q - prod_q; state_d = S_BP3; end
      S_BP3: begin acc_d = acc_q + prod_q; state_d = S_BP4; end
      S_BP4: begin
        // Band-pass output goes out one sample late
        hf_d  = bh0_q;
        bh1_d = bh0_q;
        bh0_d = sat32(rnd_shr(acc_q, 6'd30));
        bh2_d = sample_q;
        cor_cmd.start = 1'b1;
        phase_acc_d = phase_acc_q + phase_step_q;
        state_d = S_SC_WAIT;
      end
      S_SC_WAIT: begin
        if (cor_done) begin
          s_d = cor_y;
          c_d = cor_x;
          state_d = S_DM0;
        end
      end
      S_DM0: state_d = S_DM1;
      S_DM1: begin tmp_d = r30[35:0]; state_d = S_DM2; end
      S_DM2: state_d = S_DM3;
      S_DM3: begin pv_d = sat32(r16); state_d = S_LP0; end
      S_LP0: state_d = S_LP1;
      S_LP1: begin acc_d = prod_q;         state_d = S_LP2; end
      S_LP2: begin acc_d = acc_q - prod_q; state_d = S_LP3; end
      S_LP3: begin acc_d = acc_q + prod_q; state_d = S_LP4; end
      S_LP4: begin acc_d = acc_q + prod_q; state_d = S_LP5; end
      S_LP5: begin
        v_d = sat32(rnd_shr(acc_q, 6'd30));
        lh1_d[k_q] = lh0_q[k_q];
        lh0_d[k_q] = sat32(rnd_shr(acc_q, 6'd30));
        lh2_d[k_q] = pv_q;
        state_d = S_SQ0;
      end
      S_SQ0: state_d = S_SQ1;
      S_SQ1: begin
        // Saturating running sum, then mean = sum / (count + 1)
        sum_d[k_q] = sum_new;
        div_start  = 1'b1;
        state_d    = S_MEAN;
      end
      S_MEAN: begin
        if (div_done) begin
          sq_start = 1'b1;
          state_d  = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sq_done) begin
          rms_d[k_q] = sq_root;
          if (!k_q) begin
            k_d     = 1'b1;
            state_d = S_DM0;
          end else begin
            state_d = S_VEC;
          end
        end
      end
      S_VEC: begin
        if (count_q != '1) count_d = count_q + 32'd1;
        cor_cmd = '{start: 1'b1, vector_mode: 1'b1};
        state_d = S_VEC_WAIT;
      end
      S_VEC_WAIT: begin
        if (cor_done) begin
          vx_d  = cor_x;
          ang_d = cor_z[31:0];
          state_d = S_MAG0;
        end
      end
      S_MAG0: state_d = S_MAG1;
      S_MAG1: begin
        mag_d = r30[35:0];
        if (r30 <= 72'sd0) begin
          zero_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_ZNUM;
        end
      end
      S_ZNUM: begin
        // Rounded quotient: (num + m/2) / m
        div_dvd   = prod_q[63:0] + 64'(mag_q[35:1]);
        div_dsr   = 64'(mag_q);
        div_start = 1'b1;
        state_d   = S_ZDIV;
      end
      S_ZDIV: begin
        if (div_done) begin
          if (div_quo > Z_LIMIT_U) begin
            zero_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            zq_d     = 36'(div_quo[27:0]);
            cor_turn = 32'd0 - ang_q;
            cor_cmd.start = 1'b1;
            state_d  = S_ROT_WAIT;
          end
        end
      end
      S_ROT_WAIT: begin
        if (cor_done) begin
          s_d = cor_y;
          c_d = cor_x;
          state_d = S_RS0;
        end
      end
      S_RS0: state_d = S_RS1;
      S_RS1: begin
        if (r30 > Z_LIMIT_S) rs_d = Z_LIMIT_S[28:0];
        else if (r30 < -Z_LIMIT_S) rs_d = 29'(-Z_LIMIT_S);
        else rs_d = r30[28:0];
        state_d = S_LS0;
      end
      S_LS0: begin tmp_d = r30[35:0]; state_d = S_LS1; end
      S_LS1: state_d = S_LS2;
      S_LS2: begin ls_d = sat32(-r25); state_d = S_OUT; end
      S_OUT: begin
        // Hold until the output register is free
        if (out_free) begin
          res_d       = zero_q ? 29'sd0 : rs_q;
          ind_d       = zero_q ? 32'sd0 : ls_q;
          izero_d     = zero_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control, configuration and persistent filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      k_q            <= 1'b0;
      phase_step_q   <= 32'd107374182;
      phase_offset_q <= 32'd0;
      demod_gain_q   <= 16'd4096;
      inject_ampl_q  <= 16'd256;
      inv_omega_q    <= 32'd1367130;
      phase_acc_q    <= '0;
      bh0_q <= '0; bh1_q <= '0; bh2_q <= '0;
      lh0_q <= '{default: '0};
      lh1_q <= '{default: '0};
      lh2_q <= '{default: '0};
      sum_q <= '{default: '0};
      count_q <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
      phase_acc_q <= phase_acc_d;
      bh0_q <= bh0_d; bh1_q <= bh1_d; bh2_q <= bh2_d;
      lh0_q <= lh0_d; lh1_q <= lh1_d; lh2_q <= lh2_d;
      sum_q <= sum_d;
      count_q <= count_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
          CFG_PHASE_OFFSET: phase_offset_q <= cfg_data_i;
          CFG_DEMOD_GAIN:   demod_gain_q   <= cfg_data_i[15:0];
          CFG_INJECT_AMPL:  inject_ampl_q  <= cfg_data_i[15:0];
          CFG_INV_OMEGA:    inv_omega_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk_i) begin
    prod_q   <= mul_a * mul_b;
    sample_q <= sample_d;
    acc_q <= acc_d; hf_q <= hf_d; pv_q <= pv_d; v_q <= v_d;
    s_q <= s_d; c_q <= c_d; tmp_q <= tmp_d;
    vx_q <= vx_d; mag_q <= mag_d; zq_q <= zq_d;
    rms_q <= rms_d; ang_q <= ang_d;
    rs_q <= rs_d; ls_q <= ls_d; zero_q <= zero_d;
    res_q <= res_d; ind_q <= ind_d; izero_q <= izero_d;
  end

  assign out_valid_o        = out_valid_q;
  assign resistance_o       = res_q;
  assign inductance_o       = ind_q;
  assign impedance_zeroed_o = izero_q;

  // A zeroed impedance forces both estimates to zero
  a_zeroed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && impedance_zeroed_o |-> resistance_o == 29'sd0 && inductance_o == 32'sd0)
    else $error("zeroed result carries nonzero estimates");

  // Resistance stays within the ten-ohm limit
  a_rs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> resistance_o <= 29'sd167772160 && resistance_o >= -29'sd167772160)
    else $error("resistance outside limit");

  // A new result word only comes from the output state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("result word raised outside output state");

  // An accepted sample starts the band-pass sequence
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == S_BP0)
    else $error("accepted sample did not start the sequence");

endmodule
